// ----- hw/rtl/qos_pkg.sv -----
// Shared types and constants of the queue occupancy statistics block.
package qos_pkg;

    localparam int TIME_W    = 48;
    localparam int RATE_W    = 24;
    localparam int PLEN_W    = 16;
    localparam int OUT_CNT_W = 32;
    localparam int AREA_W    = 64;
    localparam int DIV_W     = 48;
    localparam int STEP_W    = 6;
    localparam int PART_W    = 24;
    localparam int PP_W      = 56;
    localparam int PROD_W    = 80;
    localparam int OCC_W     = 17;
    localparam int STAT_W    = 2;
    localparam int KIND_W    = 2;

    localparam logic [RATE_W-1:0] LINK_RATE_RESET = 24'd73500;

    localparam logic [KIND_W-1:0] KIND_ARRIVAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEPART  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd2;

    localparam logic [KIND_W-1:0] OP_ARRIVAL = 2'd0;
    localparam logic [KIND_W-1:0] OP_DEPART  = 2'd1;
    localparam logic [KIND_W-1:0] OP_SAMPLE  = 2'd2;
    localparam logic [KIND_W-1:0] OP_IGNORE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY_DEPART = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIV_ZERO     = 2'd2;
    localparam logic [STAT_W-1:0] ST_SATURATED    = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] op;
        logic [TIME_W-1:0] timestamp;
        logic [PLEN_W-1:0] packet_length;
    } t_cmd;

    typedef struct packed {
        logic [TIME_W-1:0]    service_end;
        logic [OUT_CNT_W-1:0] queue_length;
        logic [OUT_CNT_W-1:0] max_queue;
        logic [31:0]          mean_in_system;
        logic [TIME_W-1:0]    mean_wait;
        logic [31:0]          arrival_rate;
        logic [31:0]          little_error;
        logic [OCC_W-1:0]     occupancy;
        logic [STAT_W-1:0]    status;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem_init;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- hw/rtl/qos_fifo.sv -----
// Small register queue used between front, back and the result port.
module qos_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;

    logic w_wr;
    logic w_rd;

    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/qos_front.sv -----
// Front end: accepts event requests and decodes them into commands.
module qos_front (
    input  logic                                i_push,
    input  logic [qos_pkg::KIND_W-1:0]          i_kind,
    input  logic [qos_pkg::TIME_W-1:0]          i_timestamp,
    input  logic [qos_pkg::PLEN_W-1:0]          i_packet_length,
    output logic                                o_full,
    input  logic                                i_cmd_full,
    output logic                                o_cmd_wr,
    output qos_pkg::t_cmd                       o_cmd
);
    import qos_pkg::*;

    logic [KIND_W-1:0] w_op;

    always_comb begin
        case (i_kind)
            KIND_ARRIVAL: w_op = OP_ARRIVAL;
            KIND_DEPART:  w_op = OP_DEPART;
            KIND_SAMPLE:  w_op = OP_SAMPLE;
            default:      w_op = OP_IGNORE;
        endcase
    end

    assign o_full                = i_cmd_full;
    assign o_cmd_wr              = i_push && !i_cmd_full;
    assign o_cmd.op              = w_op;
    assign o_cmd.timestamp       = i_timestamp;
    assign o_cmd.packet_length   = i_packet_length;

endmodule

// ----- hw/rtl/qos_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module qos_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qos_pkg::t_div_req i_req,
    output qos_pkg::t_div_rsp o_rsp
);
    import qos_pkg::*;

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W:0] w_trial;
    logic [DIV_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_num[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_num <= i_req.num;
            r_div <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- hw/rtl/qos_back.sv -----
// Back end: queue state, area accumulation and the sample statistics.
module qos_back #(
    parameter int TIME_FRAC_BITS = 24,
    parameter int COUNT_BITS     = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [qos_pkg::RATE_W-1:0]     i_cfg_link_rate,
    input  logic                           i_cmd_empty,
    input  qos_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_rd,
    input  logic                           i_res_full,
    output logic                           o_res_wr,
    output qos_pkg::t_result               o_res,
    output qos_pkg::t_div_req              o_div_req,
    input  qos_pkg::t_div_rsp              i_div_rsp
);
    import qos_pkg::*;

    localparam int CB  = COUNT_BITS;
    localparam int TFB = TIME_FRAC_BITS;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ADV_M0    = 4'd1;
    localparam logic [3:0] S_ADV_M1    = 4'd2;
    localparam logic [3:0] S_ADV_SUM   = 4'd3;
    localparam logic [3:0] S_ADV_ACC   = 4'd4;
    localparam logic [3:0] S_DIV_SETUP = 4'd5;
    localparam logic [3:0] S_DIV_RUN   = 4'd6;
    localparam logic [3:0] S_SVC_END   = 4'd7;
    localparam logic [3:0] S_COUNT     = 4'd8;
    localparam logic [3:0] S_LIT_M0    = 4'd9;
    localparam logic [3:0] S_LIT_M1    = 4'd10;
    localparam logic [3:0] S_LIT_SUM   = 4'd11;
    localparam logic [3:0] S_LIT_EVAL  = 4'd12;
    localparam logic [3:0] S_EMIT      = 4'd13;

    localparam logic [2:0] J_DUR  = 3'd0;
    localparam logic [2:0] J_MEAN = 3'd1;
    localparam logic [2:0] J_RATE = 3'd2;
    localparam logic [2:0] J_WAIT = 3'd3;
    localparam logic [2:0] J_OCC  = 3'd4;

    localparam logic [STEP_W-1:0] STEPS_FULL = STEP_W'(DIV_W);
    localparam logic [STEP_W-1:0] STEPS_WORD = STEP_W'(32);
    localparam logic [STEP_W-1:0] STEPS_OCC  = STEP_W'(OCC_W);

    localparam logic [CB-1:0]     CNT_MAX  = {CB{1'b1}};
    localparam logic [DIV_W-1:0]  WORD_MAX = DIV_W'(32'hFFFF_FFFF);
    localparam logic [DIV_W-1:0]  OCC_MAX  = DIV_W'(65536);

    logic [3:0]          r_state, n_state;
    logic [2:0]          r_job, n_job;
    t_cmd                r_cmd, n_cmd;
    logic [RATE_W-1:0]   r_link_rate, n_link_rate;
    logic [CB-1:0]       r_in_sys, n_in_sys;
    logic [CB-1:0]       r_peak, n_peak;
    logic [CB-1:0]       r_arr_cnt, n_arr_cnt;
    logic [AREA_W-1:0]   r_area, n_area;
    logic [TIME_W-1:0]   r_prev, n_prev;
    logic [TIME_W-1:0]   r_busy, n_busy;
    logic [TIME_W-1:0]   r_finish, n_finish;
    logic [TIME_W-1:0]   r_delta, n_delta;
    logic [PP_W-1:0]     r_pp0, n_pp0;
    logic [PP_W-1:0]     r_pp1, n_pp1;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [TIME_W-1:0]   r_dur, n_dur;
    logic [31:0]         r_mean, n_mean;
    logic [31:0]         r_rate, n_rate;
    logic [TIME_W-1:0]   r_wait, n_wait;
    logic [31:0]         r_little, n_little;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic                r_sat, n_sat;
    logic                r_dz, n_dz;
    logic                r_empty_dep, n_empty_dep;

    logic [63:0]         w_dur_num;
    logic [PROD_W-1:0]   w_rate_num;
    logic [TIME_W-1:0]   w_denom;
    logic [DIV_W-1:0]    w_hi, w_lo, w_d, w_limit;
    logic [STEP_W-1:0]   w_steps;
    logic                w_fin;
    logic [DIV_W-1:0]    w_val;
    logic [AREA_W:0]     w_area_sum;
    logic [TIME_W:0]     w_fin_sum;
    logic [TIME_W:0]     w_busy_sum;
    logic [63:0]         w_pr;
    logic                w_big;
    logic [63:0]         w_mean64;
    logic [63:0]         w_d_up;
    logic [63:0]         w_d_dn;

    function automatic logic [3:0] svc_state(logic [KIND_W-1:0] op, logic [CB-1:0] n);
        logic [3:0] s;
        s = S_COUNT;
        if (op == OP_SAMPLE) begin
            s = S_DIV_SETUP;
        end else if (op == OP_ARRIVAL && n == '0) begin
            s = S_DIV_SETUP;
        end else if (op == OP_DEPART && n != CB'(1)) begin
            s = S_DIV_SETUP;
        end
        return s;
    endfunction

    assign w_dur_num  = {{(64-PLEN_W){1'b0}}, r_cmd.packet_length} << TFB;
    assign w_rate_num = {{(PROD_W-CB){1'b0}}, r_arr_cnt} << (16 + TFB);
    assign w_denom    = (r_cmd.timestamp > r_finish) ? r_cmd.timestamp : r_finish;
    assign w_area_sum = {1'b0, r_area} + {1'b0, r_prod[AREA_W-1:0]};
    assign w_fin_sum  = {1'b0, r_cmd.timestamp} + {1'b0, r_dur};
    assign w_busy_sum = {1'b0, r_busy} + {1'b0, r_dur};
    assign w_pr       = 64'(r_prod >> TFB);
    assign w_big      = ((r_prod >> (64 + TFB)) != '0);
    assign w_mean64   = {32'b0, r_mean};
    assign w_d_up     = w_pr - w_mean64;
    assign w_d_dn     = w_mean64 - w_pr;

    always_comb begin
        case (r_job)
            J_DUR: begin
                w_hi    = DIV_W'(w_dur_num[63:DIV_W]);
                w_lo    = w_dur_num[DIV_W-1:0];
                w_d     = DIV_W'(r_link_rate);
                w_steps = STEPS_FULL;
                w_limit = {DIV_W{1'b1}};
            end
            J_MEAN: begin
                w_hi    = r_area[63:16];
                w_lo    = {r_area[15:0], 32'b0};
                w_d     = r_cmd.timestamp;
                w_steps = STEPS_WORD;
                w_limit = WORD_MAX;
            end
            J_RATE: begin
                w_hi    = w_rate_num[79:32];
                w_lo    = {w_rate_num[31:0], 16'b0};
                w_d     = r_cmd.timestamp;
                w_steps = STEPS_WORD;
                w_limit = WORD_MAX;
            end
            J_WAIT: begin
                w_hi    = DIV_W'(r_area[63:48]);
                w_lo    = r_area[47:0];
                w_d     = DIV_W'(r_arr_cnt);
                w_steps = STEPS_FULL;
                w_limit = {DIV_W{1'b1}};
            end
            default: begin
                w_hi    = {1'b0, r_busy[TIME_W-1:1]};
                w_lo    = {r_busy[0], {(DIV_W-1){1'b0}}};
                w_d     = w_denom;
                w_steps = STEPS_OCC;
                w_limit = OCC_MAX;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_cmd       = r_cmd;
        n_link_rate = r_link_rate;
        n_in_sys    = r_in_sys;
        n_peak      = r_peak;
        n_arr_cnt   = r_arr_cnt;
        n_area      = r_area;
        n_prev      = r_prev;
        n_busy      = r_busy;
        n_finish    = r_finish;
        n_delta     = r_delta;
        n_pp0       = r_pp0;
        n_pp1       = r_pp1;
        n_prod      = r_prod;
        n_dur       = r_dur;
        n_mean      = r_mean;
        n_rate      = r_rate;
        n_wait      = r_wait;
        n_little    = r_little;
        n_occ       = r_occ;
        n_sat       = r_sat;
        n_dz        = r_dz;
        n_empty_dep = r_empty_dep;
        o_cmd_rd    = 1'b0;
        o_res_wr    = 1'b0;
        w_fin       = 1'b0;
        w_val       = '0;

        o_div_req.start    = 1'b0;
        o_div_req.rem_init = w_hi;
        o_div_req.num      = w_lo;
        o_div_req.divisor  = w_d;
        o_div_req.steps    = w_steps;

        if (i_cfg_valid) begin
            n_link_rate = i_cfg_link_rate;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_rd    = 1'b1;
                    n_cmd       = i_cmd;
                    n_sat       = 1'b0;
                    n_dz        = 1'b0;
                    n_empty_dep = 1'b0;
                    n_dur       = '0;
                    n_mean      = '0;
                    n_rate      = '0;
                    n_wait      = '0;
                    n_little    = '0;
                    n_occ       = '0;
                    n_delta     = i_cmd.timestamp - r_prev;
                    n_job       = (i_cmd.op == OP_SAMPLE) ? J_MEAN : J_DUR;
                    if (i_cmd.op == OP_IGNORE) begin
                        n_state = S_EMIT;
                    end else if (i_cmd.op == OP_DEPART && r_in_sys == '0) begin
                        n_empty_dep = 1'b1;
                        n_state     = S_EMIT;
                    end else if (i_cmd.timestamp > r_prev) begin
                        n_state = S_ADV_M0;
                    end else begin
                        n_state = svc_state(i_cmd.op, r_in_sys);
                    end
                end
            end
            S_ADV_M0: begin
                n_pp0   = PP_W'(r_delta[PART_W-1:0]) * PP_W'(r_in_sys);
                n_state = S_ADV_M1;
            end
            S_ADV_M1: begin
                n_pp1   = PP_W'(r_delta[TIME_W-1:PART_W]) * PP_W'(r_in_sys);
                n_state = S_ADV_SUM;
            end
            S_ADV_SUM: begin
                n_prod  = PROD_W'(r_pp0) + (PROD_W'(r_pp1) << PART_W);
                n_state = S_ADV_ACC;
            end
            S_ADV_ACC: begin
                if (r_prod[PROD_W-1:AREA_W] != '0 || w_area_sum[AREA_W]) begin
                    n_area = {AREA_W{1'b1}};
                    n_sat  = 1'b1;
                end else begin
                    n_area = w_area_sum[AREA_W-1:0];
                end
                n_prev  = r_cmd.timestamp;
                n_state = svc_state(r_cmd.op, r_in_sys);
            end
            S_DIV_SETUP: begin
                if (w_d == '0) begin
                    n_dz  = 1'b1;
                    w_fin = 1'b1;
                end else if (w_hi >= w_d) begin
                    n_sat = 1'b1;
                    w_fin = 1'b1;
                    w_val = w_limit;
                end else begin
                    o_div_req.start = 1'b1;
                    n_state         = S_DIV_RUN;
                end
            end
            S_DIV_RUN: begin
                if (i_div_rsp.done) begin
                    w_fin = 1'b1;
                    w_val = i_div_rsp.quotient;
                    if (r_job == J_OCC && i_div_rsp.quotient > OCC_MAX) begin
                        w_val = OCC_MAX;
                        n_sat = 1'b1;
                    end
                end
            end
            S_SVC_END: begin
                if (w_fin_sum[TIME_W]) begin
                    n_finish = {TIME_W{1'b1}};
                    n_sat    = 1'b1;
                end else begin
                    n_finish = w_fin_sum[TIME_W-1:0];
                end
                if (w_busy_sum[TIME_W]) begin
                    n_busy = {TIME_W{1'b1}};
                    n_sat  = 1'b1;
                end else begin
                    n_busy = w_busy_sum[TIME_W-1:0];
                end
                n_state = S_COUNT;
            end
            S_COUNT: begin
                if (r_cmd.op == OP_ARRIVAL) begin
                    if (r_in_sys == CNT_MAX) begin
                        n_sat = 1'b1;
                    end else begin
                        n_in_sys = r_in_sys + 1'b1;
                    end
                    if (n_in_sys > r_peak) begin
                        n_peak = n_in_sys;
                    end
                    if (r_arr_cnt == CNT_MAX) begin
                        n_sat = 1'b1;
                    end else begin
                        n_arr_cnt = r_arr_cnt + 1'b1;
                    end
                end else begin
                    n_in_sys = r_in_sys - 1'b1;
                end
                n_state = S_EMIT;
            end
            S_LIT_M0: begin
                n_pp0   = PP_W'(r_rate) * PP_W'(r_wait[PART_W-1:0]);
                n_state = S_LIT_M1;
            end
            S_LIT_M1: begin
                n_pp1   = PP_W'(r_rate) * PP_W'(r_wait[TIME_W-1:PART_W]);
                n_state = S_LIT_SUM;
            end
            S_LIT_SUM: begin
                n_prod  = PROD_W'(r_pp0) + (PROD_W'(r_pp1) << PART_W);
                n_state = S_LIT_EVAL;
            end
            S_LIT_EVAL: begin
                if (w_big || w_pr > w_mean64) begin
                    if (w_big || w_d_up > 64'h8000_0000) begin
                        n_little = 32'h8000_0000;
                        n_sat    = 1'b1;
                    end else begin
                        n_little = 32'(64'd0 - w_d_up);
                    end
                end else if (w_d_dn > 64'h7FFF_FFFF) begin
                    n_little = 32'h7FFF_FFFF;
                    n_sat    = 1'b1;
                end else begin
                    n_little = w_d_dn[31:0];
                end
                n_job   = J_OCC;
                n_state = S_DIV_SETUP;
            end
            S_EMIT: begin
                o_res_wr = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            case (r_job)
                J_DUR: begin
                    n_dur   = w_val;
                    n_state = S_SVC_END;
                end
                J_MEAN: begin
                    n_mean  = w_val[31:0];
                    n_job   = J_RATE;
                    n_state = S_DIV_SETUP;
                end
                J_RATE: begin
                    n_rate  = w_val[31:0];
                    n_job   = J_WAIT;
                    n_state = S_DIV_SETUP;
                end
                J_WAIT: begin
                    n_wait = w_val;
                    if (r_cmd.timestamp != '0 && r_arr_cnt != '0) begin
                        n_state = S_LIT_M0;
                    end else begin
                        n_job   = J_OCC;
                        n_state = S_DIV_SETUP;
                    end
                end
                default: begin
                    n_occ   = w_val[OCC_W-1:0];
                    n_state = S_EMIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= J_DUR;
            r_link_rate <= LINK_RATE_RESET;
            r_in_sys    <= '0;
            r_peak      <= '0;
            r_arr_cnt   <= '0;
            r_area      <= '0;
            r_prev      <= '0;
            r_busy      <= '0;
            r_finish    <= '0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_link_rate <= n_link_rate;
            r_in_sys    <= n_in_sys;
            r_peak      <= n_peak;
            r_arr_cnt   <= n_arr_cnt;
            r_area      <= n_area;
            r_prev      <= n_prev;
            r_busy      <= n_busy;
            r_finish    <= n_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_delta     <= n_delta;
        r_pp0       <= n_pp0;
        r_pp1       <= n_pp1;
        r_prod      <= n_prod;
        r_dur       <= n_dur;
        r_mean      <= n_mean;
        r_rate      <= n_rate;
        r_wait      <= n_wait;
        r_little    <= n_little;
        r_occ       <= n_occ;
        r_sat       <= n_sat;
        r_dz        <= n_dz;
        r_empty_dep <= n_empty_dep;
    end

    assign o_res.service_end    = r_finish;
    assign o_res.queue_length   = OUT_CNT_W'(r_in_sys);
    assign o_res.max_queue      = OUT_CNT_W'(r_peak);
    assign o_res.mean_in_system = r_mean;
    assign o_res.mean_wait      = r_wait;
    assign o_res.arrival_rate   = r_rate;
    assign o_res.little_error   = r_little;
    assign o_res.occupancy      = r_occ;
    assign o_res.status         = r_empty_dep ? ST_EMPTY_DEPART :
                                  r_sat       ? ST_SATURATED    :
                                  r_dz        ? ST_DIV_ZERO     : ST_OK;

`ifndef SYNTH
    a_peak_covers_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_sys <= r_peak)
        else $error("queue length above its recorded peak");

    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_prev >= $past(r_prev))
        else $error("area time base moved backwards");

    a_div_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> (o_div_req.divisor != '0) &&
                            (o_div_req.rem_init < o_div_req.divisor))
        else $error("divider started with an overflowing or zero divisor");

    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_wr |-> !i_res_full)
        else $error("result written into a full result queue");
`endif

endmodule

// ----- hw/rtl/queue_occupancy_statistics.sv -----
// Top level of the queue occupancy statistics monitor.
//
//   channel   direction  handshake               payload
//   event     in         push / full             i_kind, i_timestamp, i_packet_length
//   result    out        pop / empty             o_service_end ... o_status
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_link_rate
//
// Arrival or departure: a new service runs a 48-step division.
// Sample: runs one shared divider that yields one quotient
// bit per cycle for four quotients, plus two partial products per wide multiply.
// Reset is synchronous; it clears all counters, times and area, link_rate returns to 73500.
// Two-entry queues sit on both sides; the back end waits while the result queue is full.
module queue_occupancy_statistics #(
    parameter int TIME_FRAC_BITS = 24,
    parameter int COUNT_BITS     = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [qos_pkg::KIND_W-1:0]           i_kind,
    input  logic [qos_pkg::TIME_W-1:0]           i_timestamp,
    input  logic [qos_pkg::PLEN_W-1:0]           i_packet_length,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [qos_pkg::TIME_W-1:0]           o_service_end,
    output logic [qos_pkg::OUT_CNT_W-1:0]        o_queue_length,
    output logic [qos_pkg::OUT_CNT_W-1:0]        o_max_queue,
    output logic [31:0]                          o_mean_in_system,
    output logic [qos_pkg::TIME_W-1:0]           o_mean_wait,
    output logic [31:0]                          o_arrival_rate,
    output logic signed [31:0]                   o_little_error,
    output logic [qos_pkg::OCC_W-1:0]            o_occupancy,
    output logic [qos_pkg::STAT_W-1:0]           o_status,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [qos_pkg::RATE_W-1:0]           i_cfg_link_rate
);
    import qos_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    t_cmd       w_cmd_in;
    t_cmd       w_cmd_out;
    logic       w_cmd_wr;
    logic       w_cmd_full;
    logic       w_cmd_rd;
    logic       w_cmd_empty;
    t_result    w_res_in;
    t_result    w_res_out;
    logic       w_res_wr;
    logic       w_res_full;
    t_div_req   w_div_req;
    t_div_rsp   w_div_rsp;

    assign o_cfg_ready = 1'b1;

    qos_front u_front (
        .i_push          (push),
        .i_kind          (i_kind),
        .i_timestamp     (i_timestamp),
        .i_packet_length (i_packet_length),
        .o_full          (full),
        .i_cmd_full      (w_cmd_full),
        .o_cmd_wr        (w_cmd_wr),
        .o_cmd           (w_cmd_in)
    );

    qos_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cmd_wr),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_rd    (w_cmd_rd),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    qos_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    qos_back #(
        .TIME_FRAC_BITS (TIME_FRAC_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_link_rate (i_cfg_link_rate),
        .i_cmd_empty     (w_cmd_empty),
        .i_cmd           (w_cmd_out),
        .o_cmd_rd        (w_cmd_rd),
        .i_res_full      (w_res_full),
        .o_res_wr        (w_res_wr),
        .o_res           (w_res_in),
        .o_div_req       (w_div_req),
        .i_div_rsp       (w_div_rsp)
    );

    qos_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_wr),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_rd    (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_service_end    = w_res_out.service_end;
    assign o_queue_length   = w_res_out.queue_length;
    assign o_max_queue      = w_res_out.max_queue;
    assign o_mean_in_system = w_res_out.mean_in_system;
    assign o_mean_wait      = w_res_out.mean_wait;
    assign o_arrival_rate   = w_res_out.arrival_rate;
    assign o_little_error   = w_res_out.little_error;
    assign o_occupancy      = w_res_out.occupancy;
    assign o_status         = w_res_out.status;

endmodule
